### src/pdh_pkg.sv
package pdh_pkg;

    // Default store geometry
    localparam int MAX_BINS   = 1024;
    localparam int COUNT_BITS = 32;

    // Field and register widths
    localparam int COORD_W = 32;
    localparam int BOX_W   = 31;
    localparam int BINC_W  = 10;
    localparam int VALUE_W = 32;
    localparam int STEP_W  = 6;

    // Step counts of the iterative units
    localparam int DIV_STEPS  = 33;
    localparam int SQRT_STEPS = 32;
    localparam int SQ_STEPS   = 4;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_ACC  = 2'd0,
        KIND_READ = 2'd1,
        KIND_RCLR = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_BOX_X = 3'd0,
        REG_BOX_Y = 3'd1,
        REG_BOX_Z = 3'd2,
        REG_INV_W = 3'd3,
        REG_BINC  = 3'd4,
        REG_INTRA = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_SQ,
        ST_SQRT,
        ST_MUL,
        ST_BIN,
        ST_UPD,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       sq_step;
        logic [1:0] sq_idx;
        logic       sq_last;
        logic       sqrt_step;
        logic       bin_mul;
        logic       bin_form;
        logic       mem_rd;
        logic       mem_upd;
        logic       out_load;
        logic       clr_step;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        kind_t kind;
        logic  skip;
        logic  read_ok;
        logic  in_range;
        logic  clr_last;
        logic  out_free;
    } status_t;

    // Saturate a count to the width of the result field
    function automatic logic [VALUE_W-1:0] sat_out(input logic [63:0] v);
        logic [VALUE_W-1:0] r;
        r = (|v[63:VALUE_W]) ? '1 : v[VALUE_W-1:0];
        return r;
    endfunction

endpackage

### src/pdh_ctrl.sv
module pdh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pdh_pkg::status_t  status,
    output pdh_pkg::cmd_t     cmd
);

    pdh_pkg::state_t state_reg, state_next;
    logic [pdh_pkg::STEP_W-1:0] cnt_reg, cnt_next;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdh_pkg::ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            pdh_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                    state_next = pdh_pkg::ST_IDLE;
            end
            pdh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = pdh_pkg::ST_DECODE;
                end
            end
            pdh_pkg::ST_DECODE:
            begin
                cnt_next = '0;
                case (status.kind)
                    pdh_pkg::KIND_ACC:
                        state_next = status.skip ? pdh_pkg::ST_OUT : pdh_pkg::ST_DIV;
                    pdh_pkg::KIND_READ, pdh_pkg::KIND_RCLR:
                    begin
                        if (status.read_ok)
                        begin
                            cmd.mem_rd = 1'b1;
                            state_next = pdh_pkg::ST_UPD;
                        end
                        else
                            state_next = pdh_pkg::ST_OUT;
                    end
                    default:
                        state_next = pdh_pkg::ST_OUT;
                endcase
            end
            pdh_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == pdh_pkg::STEP_W'(pdh_pkg::DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = pdh_pkg::ST_SQ;
                end
            end
            pdh_pkg::ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                cmd.sq_idx  = cnt_reg[1:0];
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == pdh_pkg::STEP_W'(pdh_pkg::SQ_STEPS - 1))
                begin
                    cmd.sq_last = 1'b1;
                    cnt_next    = '0;
                    state_next  = pdh_pkg::ST_SQRT;
                end
            end
            pdh_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == pdh_pkg::STEP_W'(pdh_pkg::SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = pdh_pkg::ST_MUL;
                end
            end
            pdh_pkg::ST_MUL:
            begin
                cmd.bin_mul = 1'b1;
                state_next  = pdh_pkg::ST_BIN;
            end
            pdh_pkg::ST_BIN:
            begin
                cmd.bin_form = 1'b1;
                if (status.in_range)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = pdh_pkg::ST_UPD;
                end
                else
                    state_next = pdh_pkg::ST_OUT;
            end
            pdh_pkg::ST_UPD:
            begin
                cmd.mem_upd = 1'b1;
                state_next  = pdh_pkg::ST_OUT;
            end
            pdh_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pdh_pkg::ST_IDLE;
                end
            end
            default:
                state_next = pdh_pkg::ST_IDLE;
        endcase
    end

    // An item always passes through the decode state, so no two requests are accepted back to back
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted in consecutive cycles");

    // No request is taken while the store is being cleared
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pdh_pkg::ST_CLEAR |-> !cmd.load)
        else $error("request accepted during clearing pass");

    // The output register is only loaded when it is free
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a waiting result");

endmodule

### src/pdh_datapath.sv
module pdh_datapath #(
    parameter int MAX_BINS   = pdh_pkg::MAX_BINS,
    parameter int COUNT_BITS = pdh_pkg::COUNT_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pdh_pkg::cmd_t               cmd,
    output pdh_pkg::status_t            status,
    input  logic [1:0]                  in_kind,
    input  logic [207:0]                in_data,
    input  logic [pdh_pkg::BOX_W-1:0]   box_x,
    input  logic [pdh_pkg::BOX_W-1:0]   box_y,
    input  logic [pdh_pkg::BOX_W-1:0]   box_z,
    input  logic [pdh_pkg::BOX_W-1:0]   inv_bin_width,
    input  logic [pdh_pkg::BINC_W-1:0]  bin_count,
    input  logic                        count_intramolecular,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [pdh_pkg::BINC_W-1:0]  out_hit_bin,
    output logic                        out_counted,
    output logic [pdh_pkg::VALUE_W-1:0] out_bin_value
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int BW = pdh_pkg::BOX_W;

    // Captured request
    pdh_pkg::kind_t             kind_reg;
    logic                       same_atom_reg;
    logic                       same_mol_reg;
    logic [pdh_pkg::BINC_W-1:0] read_bin_reg;

    // Per-axis remainder lanes
    logic [32:0]   a_reg   [3];
    logic [BW-1:0] rem_reg [3];
    logic [BW-1:0] box_eff [3];
    logic [BW-1:0] mag     [3];

    // Squares, square root and bin
    logic [2*BW-3:0] sq_reg;
    logic [61:0]     acc_reg;
    logic [63:0]     x_reg, res_reg, bit_reg;
    logic [62:0]     bprod_reg;
    logic [31:0]     bin_reg, bin_comb;

    // Store and result
    logic [COUNT_BITS-1:0]       mem [MAX_BINS];
    logic [COUNT_BITS-1:0]       rdata_reg;
    logic [AW-1:0]               addr_reg, rd_addr, clr_ptr_reg;
    logic [COUNT_BITS-1:0]       inc_val;
    logic [pdh_pkg::BINC_W-1:0]  res_hit_reg;
    logic                        res_counted_reg;
    logic [pdh_pkg::VALUE_W-1:0] res_value_reg;

    // A zero box length acts as the smallest legal length
    assign box_eff[0] = (box_x == '0) ? BW'(1) : box_x;
    assign box_eff[1] = (box_y == '0) ? BW'(1) : box_y;
    assign box_eff[2] = (box_z == '0) ? BW'(1) : box_z;

    // Minimum-image magnitude from the remainder of |d| by the box length
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag[i] = ({rem_reg[i], 1'b0} >= {1'b0, box_eff[i]}) ?
                     box_eff[i] - rem_reg[i] : rem_reg[i];
    end

    // Request capture and restoring remainder lanes
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg      <= pdh_pkg::kind_t'(in_kind);
            same_atom_reg <= in_data[192];
            same_mol_reg  <= in_data[193];
            read_bin_reg  <= in_data[203:194];
            for (int i = 0; i < 3; i++)
            begin
                logic [32:0] d;
                d = {in_data[96+32*i+31], in_data[96+32*i +: 32]} -
                    {in_data[32*i+31], in_data[32*i +: 32]};
                a_reg[i]   <= d[32] ? (33'd0 - d) : d;
                rem_reg[i] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [BW:0] sh;
                sh = {rem_reg[i], a_reg[i][32]};
                rem_reg[i] <= (sh >= {1'b0, box_eff[i]}) ?
                              BW'(sh - {1'b0, box_eff[i]}) : sh[BW-1:0];
                a_reg[i]   <= {a_reg[i][31:0], 1'b0};
            end
        end
    end

    // Sum of squares, one multiply a cycle, then the digit-by-digit square root
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            acc_reg <= '0;
        if (cmd.sq_step)
        begin
            if (cmd.sq_idx != 2'd3)
                sq_reg <= mag[cmd.sq_idx][BW-2:0] * mag[cmd.sq_idx][BW-2:0];
            if (cmd.sq_idx != 2'd0)
                acc_reg <= acc_reg + 62'(sq_reg);
        end
        if (cmd.sq_last)
        begin
            x_reg   <= 64'(acc_reg + 62'(sq_reg));
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (cmd.sqrt_step)
        begin
            if (x_reg >= res_reg + bit_reg)
            begin
                x_reg   <= x_reg - (res_reg + bit_reg);
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.bin_mul)
            bprod_reg <= res_reg[31:0] * inv_bin_width;
        if (cmd.bin_form)
            bin_reg <= bin_comb;
    end

    assign bin_comb = {1'b0, bprod_reg[62:32]} + 32'd1;

    // Store address and saturating increment
    assign rd_addr = (kind_reg == pdh_pkg::KIND_ACC) ? bin_comb[AW-1:0] :
                     AW'({{(32-pdh_pkg::BINC_W){1'b0}}, read_bin_reg});
    assign inc_val = (rdata_reg == '1) ? rdata_reg : rdata_reg + 1'b1;

    // Histogram store: one read and one write port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[rd_addr];
            addr_reg  <= rd_addr;
        end
        if (cmd.clr_step)
            mem[clr_ptr_reg] <= '0;
        else if (cmd.mem_upd && kind_reg == pdh_pkg::KIND_ACC)
            mem[addr_reg] <= inc_val;
        else if (cmd.mem_upd && kind_reg == pdh_pkg::KIND_RCLR)
            mem[addr_reg] <= '0;
    end

    // Clearing pointer after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_ptr_reg <= '0;
        else if (cmd.clr_step)
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
    end

    // Result of the current request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_hit_reg     <= '0;
            res_counted_reg <= 1'b0;
            res_value_reg   <= '0;
        end
        else if (cmd.mem_upd)
        begin
            if (kind_reg == pdh_pkg::KIND_ACC)
            begin
                res_hit_reg     <= bin_reg[pdh_pkg::BINC_W-1:0];
                res_counted_reg <= 1'b1;
                res_value_reg   <= pdh_pkg::sat_out(64'(inc_val));
            end
            else
                res_value_reg <= pdh_pkg::sat_out(64'(rdata_reg));
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_load)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_hit_bin   <= res_hit_reg;
            out_counted   <= res_counted_reg;
            out_bin_value <= res_value_reg;
        end
    end

    // Status to the controller
    always_comb
    begin
        status.kind     = kind_reg;
        status.skip     = same_atom_reg || (same_mol_reg && !count_intramolecular);
        status.read_ok  = {22'd0, read_bin_reg} < 32'(MAX_BINS);
        status.in_range = (bin_comb <= {22'd0, bin_count}) &&
                          (bin_comb < 32'(MAX_BINS));
        status.clr_last = clr_ptr_reg == AW'(MAX_BINS - 1);
        status.out_free = !out_valid || out_ready;
    end

    // A counted pair always names a bin from one upwards
    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_counted |-> out_hit_bin != '0)
        else $error("counted pair with bin zero");

    // Each remainder step leaves the remainder below the box length
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step && rem_reg[0] < box_eff[0] |=> rem_reg[0] < $past(box_eff[0]))
        else $error("remainder out of range");

    // A waiting result is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bin_value))
        else $error("waiting result lost");

endmodule

### src/pair_distance_histogram_top.sv
// Pair-distance histogram.
// Requests enter on the s_ stream: tuser carries the kind (accumulate pair,
// read bin, read and clear bin) and tdata the positions, flags and bin index.
// Each request gives exactly one result on the m_ stream.
// An accumulate request reduces each displacement to its minimum image with a
// one-bit-per-cycle remainder unit (all three axes side by side), sums the
// squares on one multiplier, takes the square root digit by digit and forms
// the bin, then increments that bin in the store if it is within range.
// A skipped pair and a read go to their result without this work. One request
// is in flight at a time.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; a stalled receiver holds the block at its next
// result until that register is free.
// After reset the store is cleared one entry a cycle, during which no request
// is taken; configuration writes are taken at all times and must only be made
// while the block is idle.
module pair_distance_histogram_top #(
    parameter int MAX_BINS   = pdh_pkg::MAX_BINS,
    parameter int COUNT_BITS = pdh_pkg::COUNT_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    // Request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [207:0] s_tdata,  // first_x, first_y, first_z, second_x, second_y,
                                   // second_z, same_atom, same_molecule, read_bin
    input  logic [1:0]   s_tuser,  // kind
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,  // hit_bin, counted, bin_value
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [pdh_pkg::BOX_W-1:0]   box_x_reg, box_y_reg, box_z_reg, inv_w_reg;
    logic [pdh_pkg::BINC_W-1:0]  bin_count_reg;
    logic                        intra_reg;
    logic                        wr_en;
    pdh_pkg::reg_idx_t           reg_idx;
    pdh_pkg::cmd_t               cmd;
    pdh_pkg::status_t            status;
    logic [pdh_pkg::BINC_W-1:0]  hit_bin;
    logic                        counted;
    logic [pdh_pkg::VALUE_W-1:0] bin_value;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = pdh_pkg::reg_idx_t'(paddr[4:2]);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg     <= 31'd655360;
            box_y_reg     <= 31'd655360;
            box_z_reg     <= 31'd655360;
            inv_w_reg     <= 31'd6553600;
            bin_count_reg <= 10'd1000;
            intra_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pdh_pkg::REG_BOX_X: box_x_reg     <= pwdata[30:0];
                pdh_pkg::REG_BOX_Y: box_y_reg     <= pwdata[30:0];
                pdh_pkg::REG_BOX_Z: box_z_reg     <= pwdata[30:0];
                pdh_pkg::REG_INV_W: inv_w_reg     <= pwdata[30:0];
                pdh_pkg::REG_BINC:  bin_count_reg <= pwdata[9:0];
                pdh_pkg::REG_INTRA: intra_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (reg_idx)
            pdh_pkg::REG_BOX_X: prdata = {1'b0, box_x_reg};
            pdh_pkg::REG_BOX_Y: prdata = {1'b0, box_y_reg};
            pdh_pkg::REG_BOX_Z: prdata = {1'b0, box_z_reg};
            pdh_pkg::REG_INV_W: prdata = {1'b0, inv_w_reg};
            pdh_pkg::REG_BINC:  prdata = {22'd0, bin_count_reg};
            pdh_pkg::REG_INTRA: prdata = {31'd0, intra_reg};
            default:            prdata = '0;
        endcase
    end

    pdh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pdh_datapath #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .in_kind              (s_tuser),
        .in_data              (s_tdata),
        .box_x                (box_x_reg),
        .box_y                (box_y_reg),
        .box_z                (box_z_reg),
        .inv_bin_width        (inv_w_reg),
        .bin_count            (bin_count_reg),
        .count_intramolecular (intra_reg),
        .out_ready            (m_tready),
        .out_valid            (m_tvalid),
        .out_hit_bin          (hit_bin),
        .out_counted          (counted),
        .out_bin_value        (bin_value)
    );

    assign m_tdata = {5'd0, bin_value, counted, hit_bin};

endmodule
